// File: design/trie_word_break_checker_unit_assert.svh
// Assertion shorthands for the word-break checker.
`ifndef TRIE_WORD_BREAK_CHECKER_UNIT_ASSERT_SVH
`define TRIE_WORD_BREAK_CHECKER_UNIT_ASSERT_SVH

// Checked out of reset only.
`define TWB_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) expr) \
	else $error("twb assertion failed");

// Checked at every edge, reset included.
`define TWB_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) expr) \
	else $error("twb assertion failed");

`endif

// File: design/twb_pkg.sv
`default_nettype none
package twb_pkg;
	localparam int NODES       = 1024;
	localparam int ALPHABET    = 26;
	localparam int MAX_WORD    = 32;
	localparam int NODE_W      = $clog2(NODES);
	localparam int CNT_W       = $clog2(NODES + 1);
	localparam int CHILD_DEPTH = NODES * ALPHABET;
	localparam int CADDR_W     = $clog2(CHILD_DEPTH);
	localparam int LET_W       = 5;
	localparam int DEPTH_W     = $clog2(MAX_WORD + 1);
	localparam int SLOT_W      = $clog2(MAX_WORD + 1);

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_DICT  = 2'd1,
		CMD_TEXT  = 2'd2,
		CMD_END   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
	} walker_t;

	typedef struct packed {
		logic             start;
		logic             restart;
		logic [LET_W-1:0] letter;
	} walk_ctl_t;

	typedef struct packed {
		logic done;
		logic root_valid;
	} walk_stat_t;

	function automatic logic [CADDR_W-1:0] child_addr(input logic [NODE_W-1:0] node,
			input logic [LET_W-1:0] letter);
		child_addr = CADDR_W'(node) * CADDR_W'(ALPHABET) + CADDR_W'(letter);
	endfunction
endpackage
`default_nettype wire

// File: design/trie_word_break_checker_unit.sv
// Word-break checker over a letter trie.
//
// Input stream (s_*): one transfer per command. s_tdata[1:0] is the command
// (clear, dictionary letter, text letter, end of text), s_tdata[6:2] the
// letter index, s_tlast marks the last letter of a dictionary word.
// Output stream (m_*): one transfer per end-of-text command, carrying the
// breakable bit and the sticky overflow bit.
//
// Timing: a skipped dictionary letter is taken in the idle state; one that
// reaches the trie table goes through a read state, then an allocate/write
// state. A text letter keeps the input closed while every walker slot gets
// one child table read from the single read port, pipelined with the end-mark
// read. The result of an end of text shows on m_tvalid the next cycle.
// Reset and the clear command run a clearing pass over all NODES * ALPHABET
// = 26624 child table entries (end marks cleared alongside); s_tready is
// low meanwhile. A pending result sits in the output register; while the
// receiver stalls, s_tready is held low until it is taken.
`default_nettype none
module trie_word_break_checker_unit
	import twb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [1:0] cmd, [6:2] letter, [7] zero
	input  wire logic       s_tlast,  // word_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata   // [0] breakable, [1] overflow, [7:2] zero
);
	typedef enum logic [4:0] {
		ST_SWEEP = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_DREAD = 5'b00100,
		ST_DEVAL = 5'b01000,
		ST_TEXT  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CADDR_W-1:0] sweep_q;
	logic [CNT_W-1:0]   nodes_q;
	logic [NODE_W-1:0]  cursor_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               skip_q;
	logic               ovf_q;
	logic               dlast_q;
	logic [CADDR_W-1:0] daddr_q;
	logic               out_valid_q;
	logic               out_brk_q;
	logic               out_ovf_q;

	cmd_t             cmd;
	logic [LET_W-1:0] letter;
	logic             accept;

	// table ports
	logic               ch_we;
	logic [CADDR_W-1:0] ch_waddr, ch_raddr, walk_raddr;
	logic [NODE_W-1:0]  ch_wdata, ch_rdata;
	logic               mk_we, mk_wdata, mk_rdata;
	logic [NODE_W-1:0]  mk_waddr, mk_raddr;

	walk_ctl_t  wctl;
	walk_stat_t wstat;

	// dictionary evaluation
	logic              need_node, pool_full, drop_eval;
	logic [NODE_W-1:0] next_node;

	assign cmd    = cmd_t'(s_tdata[1:0]);
	assign letter = s_tdata[6:2];

	// take a transfer only when a result, if any, has room
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_ovf_q, out_brk_q};

	assign need_node = (ch_rdata == '0);
	assign pool_full = (nodes_q >= CNT_W'(NODES));
	assign drop_eval = need_node && pool_full;
	assign next_node = need_node ? nodes_q[NODE_W-1:0] : ch_rdata;

	assign wctl.start   = accept && (cmd == CMD_TEXT);
	assign wctl.restart = accept && ((cmd == CMD_END) || (cmd == CMD_CLEAR));
	assign wctl.letter  = letter;

	always_comb begin
		ch_we    = 1'b0;
		ch_waddr = daddr_q;
		ch_wdata = nodes_q[NODE_W-1:0];
		mk_we    = 1'b0;
		mk_waddr = next_node;
		mk_wdata = 1'b1;
		case (state_q)
			ST_SWEEP: begin
				ch_we    = 1'b1;
				ch_waddr = sweep_q;
				ch_wdata = '0;
				mk_we    = (sweep_q < CADDR_W'(NODES));
				mk_waddr = sweep_q[NODE_W-1:0];
				mk_wdata = 1'b0;
			end
			ST_DEVAL: begin
				ch_we = need_node && !pool_full;
				mk_we = !drop_eval && dlast_q;
			end
			default: begin
			end
		endcase
	end

	assign ch_raddr = (state_q == ST_DREAD) ? daddr_q : walk_raddr;

	twb_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (ch_wdata),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	twb_ram #(.WIDTH(1), .DEPTH(NODES)) u_mark (
		.clk   (clk),
		.we    (mk_we),
		.waddr (mk_waddr),
		.wdata (mk_wdata),
		.raddr (mk_raddr),
		.rdata (mk_rdata)
	);

	twb_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (wctl),
		.ch_raddr (walk_raddr),
		.ch_rdata (ch_rdata),
		.mk_raddr (mk_raddr),
		.mk_rdata (mk_rdata),
		.stat     (wstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			nodes_q     <= CNT_W'(1);
			cursor_q    <= '0;
			depth_q     <= '0;
			skip_q      <= 1'b0;
			ovf_q       <= 1'b0;
			dlast_q     <= 1'b0;
			daddr_q     <= '0;
			out_valid_q <= 1'b0;
			out_brk_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (m_tready && !(accept && (cmd == CMD_END))) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == CADDR_W'(CHILD_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_CLEAR: begin
								state_q  <= ST_SWEEP;
								sweep_q  <= '0;
								nodes_q  <= CNT_W'(1);
								cursor_q <= '0;
								depth_q  <= '0;
								skip_q   <= 1'b0;
								ovf_q    <= 1'b0;
							end
							CMD_DICT: begin
								if (skip_q) begin
									if (s_tlast) begin
										skip_q   <= 1'b0;
										cursor_q <= '0;
										depth_q  <= '0;
									end
								end else if (letter >= LET_W'(ALPHABET)) begin
									cursor_q <= '0;
									depth_q  <= '0;
									skip_q   <= !s_tlast;
								end else if (depth_q >= DEPTH_W'(MAX_WORD)) begin
									cursor_q <= '0;
									depth_q  <= '0;
									skip_q   <= !s_tlast;
									ovf_q    <= 1'b1;
								end else begin
									daddr_q <= child_addr(cursor_q, letter);
									dlast_q <= s_tlast;
									state_q <= ST_DREAD;
								end
							end
							CMD_TEXT: begin
								state_q <= ST_TEXT;
							end
							CMD_END: begin
								out_valid_q <= 1'b1;
								out_brk_q   <= wstat.root_valid;
								out_ovf_q   <= ovf_q;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DREAD: begin
					state_q <= ST_DEVAL;
				end
				ST_DEVAL: begin
					state_q <= ST_IDLE;
					if (drop_eval) begin
						// pool exhausted: skip the rest of the word
						cursor_q <= '0;
						depth_q  <= '0;
						skip_q   <= !dlast_q;
						ovf_q    <= 1'b1;
					end else begin
						if (need_node) begin
							nodes_q <= nodes_q + 1'b1;
						end
						if (dlast_q) begin
							cursor_q <= '0;
							depth_q  <= '0;
						end else begin
							cursor_q <= next_node;
							depth_q  <= depth_q + 1'b1;
						end
					end
				end
				ST_TEXT: begin
					if (wstat.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/twb_ram.sv
`default_nettype none
module twb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/twb_walk.sv
`default_nettype none
module twb_walk
	import twb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire walk_ctl_t           ctl,
	output logic      [CADDR_W-1:0]  ch_raddr,
	input  wire logic [NODE_W-1:0]   ch_rdata,
	output logic      [NODE_W-1:0]   mk_raddr,
	input  wire logic                mk_rdata,
	output walk_stat_t               stat
);
	walker_t          walk_q [MAX_WORD];
	walker_t          res_q  [MAX_WORD];
	logic [SLOT_W-1:0] issue_q;
	logic             busy_q;
	logic [LET_W-1:0] letter_q;
	logic             go_s1, valid_s1, last_s1;
	logic             go_s2, nz_s2, last_s2;
	logic             hit_q;
	logic [NODE_W-1:0] child;
	logic             hit_now;

	// stage 0 reads the child slot of the head walker
	assign ch_raddr = child_addr(walk_q[0].node, letter_q);
	// stage 1 reads the end mark of the child found
	assign child    = valid_s1 ? ch_rdata : '0;
	assign mk_raddr = child;
	assign hit_now  = hit_q | (nz_s2 & mk_rdata);

	assign stat.done       = go_s2 & last_s2;
	assign stat.root_valid = walk_q[0].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q[0] <= '{valid: 1'b1, node: '0};
			res_q[0]  <= '0;
			for (int j = 1; j < MAX_WORD; j++) begin
				walk_q[j] <= '0;
				res_q[j]  <= '0;
			end
			issue_q  <= '0;
			busy_q   <= 1'b0;
			letter_q <= '0;
			go_s1    <= 1'b0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			go_s2    <= 1'b0;
			nz_s2    <= 1'b0;
			last_s2  <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			go_s1 <= busy_q;
			go_s2 <= go_s1;
			if (ctl.restart) begin
				walk_q[0] <= '{valid: 1'b1, node: '0};
				for (int j = 1; j < MAX_WORD; j++) begin
					walk_q[j] <= '0;
				end
			end else if (ctl.start) begin
				busy_q   <= 1'b1;
				issue_q  <= '0;
				letter_q <= ctl.letter;
				hit_q    <= 1'b0;
			end else if (busy_q) begin
				valid_s1 <= walk_q[0].valid && (letter_q < LET_W'(ALPHABET));
				last_s1  <= (issue_q == SLOT_W'(MAX_WORD - 1));
				for (int j = 0; j < MAX_WORD - 1; j++) begin
					walk_q[j] <= walk_q[j+1];
				end
				walk_q[MAX_WORD-1] <= walk_q[0];
				issue_q <= issue_q + 1'b1;
				if (issue_q == SLOT_W'(MAX_WORD - 1)) begin
					busy_q <= 1'b0;
				end
			end else if (go_s2 && last_s2) begin
				// walker d moves to slot d+1; the root revives on a word end
				walk_q[0].valid <= hit_now;
				walk_q[0].node  <= '0;
				for (int j = 1; j < MAX_WORD; j++) begin
					walk_q[j] <= res_q[j-1];
				end
			end
			if (go_s1) begin
				for (int j = 0; j < MAX_WORD - 1; j++) begin
					res_q[j] <= res_q[j+1];
				end
				res_q[MAX_WORD-1].valid <= (child != '0);
				res_q[MAX_WORD-1].node  <= child;
				nz_s2   <= (child != '0);
				last_s2 <= last_s1;
			end
			if (go_s2) begin
				hit_q <= hit_now;
			end
		end
	end
endmodule
`default_nettype wire

// File: design/twb_chk.sv
`default_nettype none
`include "trie_word_break_checker_unit_assert.svh"
module twb_chk
	import twb_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);
	logic text_in, end_in;

	assign text_in = s_tvalid && s_tready && (s_tdata[1:0] == CMD_TEXT);
	assign end_in  = s_tvalid && s_tready && (s_tdata[1:0] == CMD_END);

	// a stalled result holds its data
	`TWB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	// a result appears only after an end-of-text transfer
	`TWB_ASSERT(a_out_cause, $rose(m_tvalid) |-> $past(end_in))
	// a text letter keeps the input closed while the walkers step
	`TWB_ASSERT(a_text_busy, text_in |=> !s_tready)
	// unused result bits stay zero
	`TWB_ASSERT_ALWAYS(a_out_pad, !m_tvalid || (m_tdata[7:2] == 6'd0))
endmodule

bind trie_word_break_checker_unit twb_chk u_twb_chk (.*);
`default_nettype wire
